@@ design/dual_queue_valve_dosing_sequencer_top_assert.svh @@
// assertion macros for the dosing sequencer top level
`ifndef DUAL_QUEUE_VALVE_DOSING_SEQUENCER_TOP_ASSERT_SVH
`define DUAL_QUEUE_VALVE_DOSING_SEQUENCER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define DQVDS_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("dosing sequencer check failed");

// next-cycle implication, checked out of reset
`define DQVDS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("dosing sequencer check failed");

`else

`define DQVDS_ASSERT_IMPLY(label, pre, post)
`define DQVDS_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ design/dqvds_pkg.sv @@
// shared constants, types and helpers of the dosing sequencer
package dqvds_pkg;

   localparam int QUEUE_DEPTH = 3;
   localparam int NUM_VALVES  = 6;

   localparam int CNT_W   = 22;
   localparam int SEC_W   = 12;
   localparam int ID_W    = 3;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]  GAP_MS   = CNT_W'(2000);
   localparam logic [CNT_W-1:0]  MS_PER_S = CNT_W'(1000);
   localparam logic [SEC_W-1:0]  OPEN_SECONDS_RST = SEC_W'(5);

   // input mode codes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_ENQ   = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   // register index held in the address bit above the word offset
   localparam logic REG_PH_OPEN  = 1'b0;
   localparam logic REG_ORP_OPEN = 1'b1;

   // per-side command for one transaction
   typedef struct packed {
      logic tick;
      logic enq;
      logic clear;
   } side_ctrl_type;

   // per-side result of one transaction
   typedef struct packed {
      logic                  accepted;
      logic                  opened;
      logic [ID_W-1:0]       opened_valve;
      logic [NUM_VALVES-1:0] drive;
   } side_stat_type;

   // per-side timing thresholds in milliseconds
   typedef struct packed {
      logic [CNT_W-1:0] valve_ms;
      logic [CNT_W-1:0] queue_ms;
   } side_time_type;

   // saturating millisecond counter step
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

@@ design/dual_queue_valve_dosing_sequencer_top.sv @@
// top level of the two-sided valve dosing sequencer
//
//   channel   direction  handshake                fields
//   req_      in         req_valid / req_stall    mode, valve_id
//   rsp_      out        rsp_valid / rsp_stall    accepted, valve_drive, opened flags and ids
//   csr_      in/out     psel, penable, pready    ph_open_seconds, orp_open_seconds
//
// one transaction in per cycle while req_stall is low; the input register takes each
// transaction when it is accepted, and the side logic then feeds its result into the
// result register, from which it is valid.
// a stalled result holds the result register; the input register then holds and
// req_stall rises, so at most two transactions are in flight.
// reset is synchronous; queues read empty afterwards.
module dual_queue_valve_dosing_sequencer_top
   import dqvds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [ID_W-1:0]       req_valve_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic [NUM_VALVES-1:0] rsp_valve_drive,
   output logic                  rsp_ph_opened,
   output logic [ID_W-1:0]       rsp_ph_opened_valve,
   output logic                  rsp_orp_opened,
   output logic [ID_W-1:0]       rsp_orp_opened_valve,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   logic                  in_valid_ff, in_valid_in;
   mode_type              in_mode_ff, in_mode_in;
   logic [ID_W-1:0]       in_id_ff, in_id_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accepted_ff, accepted_in;
   logic [NUM_VALVES-1:0] drive_ff, drive_in;
   logic                  ph_opened_ff, ph_opened_in;
   logic [ID_W-1:0]       ph_valve_ff, ph_valve_in;
   logic                  orp_opened_ff, orp_opened_in;
   logic [ID_W-1:0]       orp_valve_ff, orp_valve_in;

   logic                  fire;
   logic                  req_take;
   logic                  id_ok;
   side_ctrl_type         ph_ctrl, orp_ctrl;
   side_stat_type         ph_stat, orp_stat;
   side_time_type         ph_times, orp_times;

   // handshake control
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_mode_in  = in_mode_ff;
      in_id_in    = in_id_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         in_mode_in = req_mode;
         in_id_in   = req_valve_id;
      end
   end

   // route the transaction to the sides
   assign id_ok = ({1'b0, in_id_ff} < (ID_W + 1)'(NUM_VALVES));

   always_comb begin
      ph_ctrl  = '0;
      orp_ctrl = '0;
      if (fire) begin
         unique case (in_mode_ff)
            MODE_TICK: begin
               ph_ctrl.tick  = 1'b1;
               orp_ctrl.tick = 1'b1;
            end
            MODE_ENQ: begin
               ph_ctrl.enq  = id_ok && !in_id_ff[0];
               orp_ctrl.enq = id_ok && in_id_ff[0];
            end
            MODE_CLEAR: begin
               ph_ctrl.clear  = 1'b1;
               orp_ctrl.clear = 1'b1;
            end
            default: begin
               ph_ctrl = '0;
            end
         endcase
      end
   end

   dqvds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .ph_times  (ph_times),
      .orp_times (orp_times)
   );

   dqvds_side u_ph_side (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ph_ctrl),
      .enq_id (in_id_ff),
      .times  (ph_times),
      .stat   (ph_stat)
   );

   dqvds_side u_orp_side (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (orp_ctrl),
      .enq_id (in_id_ff),
      .times  (orp_times),
      .stat   (orp_stat)
   );

   // result register
   always_comb begin
      rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
      accepted_in   = accepted_ff;
      drive_in      = drive_ff;
      ph_opened_in  = ph_opened_ff;
      ph_valve_in   = ph_valve_ff;
      orp_opened_in = orp_opened_ff;
      orp_valve_in  = orp_valve_ff;
      if (fire) begin
         accepted_in   = ph_stat.accepted || orp_stat.accepted;
         drive_in      = ph_stat.drive | orp_stat.drive;
         ph_opened_in  = ph_stat.opened;
         ph_valve_in   = ph_stat.opened_valve;
         orp_opened_in = orp_stat.opened;
         orp_valve_in  = orp_stat.opened_valve;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff    <= in_mode_in;
      in_id_ff      <= in_id_in;
      accepted_ff   <= accepted_in;
      drive_ff      <= drive_in;
      ph_opened_ff  <= ph_opened_in;
      ph_valve_ff   <= ph_valve_in;
      orp_opened_ff <= orp_opened_in;
      orp_valve_ff  <= orp_valve_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = accepted_ff;
   assign rsp_valve_drive      = drive_ff;
   assign rsp_ph_opened        = ph_opened_ff;
   assign rsp_ph_opened_valve  = ph_valve_ff;
   assign rsp_orp_opened       = orp_opened_ff;
   assign rsp_orp_opened_valve = orp_valve_ff;

   // checks
`include "dual_queue_valve_dosing_sequencer_top_assert.svh"

   `DQVDS_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid_ff)
   `DQVDS_ASSERT_IMPLY(a_enq_no_open, rsp_valid_ff && accepted_ff, !ph_opened_ff && !orp_opened_ff)
   `DQVDS_ASSERT_IMPLY(a_ph_even, rsp_valid_ff && ph_opened_ff, !ph_valve_ff[0])
   `DQVDS_ASSERT_IMPLY(a_orp_odd, rsp_valid_ff && orp_opened_ff, orp_valve_ff[0])

endmodule

@@ design/dqvds_side.sv @@
// one dosing side: valve queue, open timer and dequeue spacing
module dqvds_side
   import dqvds_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  side_ctrl_type   ctrl,
   input  logic [ID_W-1:0] enq_id,
   input  side_time_type   times,
   output side_stat_type   stat
);

   logic [ID_W-1:0]    fifo_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]    fifo_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               is_open_ff, is_open_in;
   logic [ID_W-1:0]    open_valve_ff, open_valve_in;
   logic [CNT_W-1:0]   elapsed_ff, elapsed_in;
   logic [CNT_W-1:0]   since_ff, since_in;

   logic [CNT_W-1:0]   elapsed_inc;
   logic [CNT_W-1:0]   since_inc;
   logic               close_now;
   logic               still_open;
   logic               pop;
   logic               enq_ok;

   // tick decisions
   assign elapsed_inc = sat_inc(elapsed_ff);
   assign since_inc   = sat_inc(since_ff);
   assign close_now   = is_open_ff && (elapsed_inc >= times.valve_ms);
   assign still_open  = is_open_ff && !close_now;
   assign pop         = !still_open && (count_ff != '0) && (since_inc >= times.queue_ms);
   assign enq_ok      = ctrl.enq && (count_ff < COUNT_W'(QUEUE_DEPTH));

   // queue storage: shift on pop, write at the fill level on enqueue
   always_comb begin
      fifo_in = fifo_ff;
      if (ctrl.tick && pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            fifo_in[i] = fifo_ff[i + 1];
         end
      end else if (enq_ok) begin
         fifo_in[count_ff[IDX_W-1:0]] = enq_id;
      end
   end

   // control state next values
   always_comb begin
      count_in      = count_ff;
      is_open_in    = is_open_ff;
      open_valve_in = open_valve_ff;
      elapsed_in    = elapsed_ff;
      since_in      = since_ff;
      if (ctrl.clear) begin
         count_in      = '0;
         is_open_in    = 1'b0;
         open_valve_in = '0;
         elapsed_in    = '0;
         since_in      = CNT_MAX;
      end else if (ctrl.tick) begin
         if (pop) begin
            count_in      = count_ff - COUNT_W'(1);
            is_open_in    = 1'b1;
            open_valve_in = fifo_ff[0];
            elapsed_in    = '0;
            since_in      = '0;
         end else begin
            is_open_in    = still_open;
            open_valve_in = close_now ? '0 : open_valve_ff;
            elapsed_in    = elapsed_inc;
            since_in      = since_inc;
         end
      end else if (enq_ok) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // transaction status from the updated state
   always_comb begin
      stat.accepted     = enq_ok;
      stat.opened       = ctrl.tick && pop;
      stat.opened_valve = (ctrl.tick && pop) ? fifo_ff[0] : '0;
      stat.drive        = '0;
      if (is_open_in && ({1'b0, open_valve_in} < (ID_W + 1)'(NUM_VALVES))) begin
         stat.drive = NUM_VALVES'(1) << open_valve_in;
      end
   end

   // queue entries carry no reset
   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         is_open_ff    <= 1'b0;
         open_valve_ff <= '0;
         elapsed_ff    <= '0;
         since_ff      <= CNT_MAX;
      end else begin
         count_ff      <= count_in;
         is_open_ff    <= is_open_in;
         open_valve_ff <= open_valve_in;
         elapsed_ff    <= elapsed_in;
         since_ff      <= since_in;
      end
   end

endmodule

@@ design/dqvds_csr.sv @@
// open-time registers with their millisecond thresholds
module dqvds_csr
   import dqvds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output side_time_type     ph_times,
   output side_time_type     orp_times
);

   logic [SEC_W-1:0] ph_seconds_ff,  ph_seconds_in;
   logic [SEC_W-1:0] orp_seconds_ff, orp_seconds_in;
   side_time_type    ph_times_ff,  ph_times_in;
   side_time_type    orp_times_ff, orp_times_in;

   logic             wr_en;
   logic             sel_reg;
   logic [CNT_W-1:0] wr_ms;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign sel_reg = paddr[2];

   // seconds to milliseconds at write time
   assign wr_ms = CNT_W'(pwdata[SEC_W-1:0]) * MS_PER_S;

   always_comb begin
      ph_seconds_in  = ph_seconds_ff;
      orp_seconds_in = orp_seconds_ff;
      ph_times_in    = ph_times_ff;
      orp_times_in   = orp_times_ff;
      if (wr_en) begin
         unique case (sel_reg)
            REG_PH_OPEN: begin
               ph_seconds_in        = pwdata[SEC_W-1:0];
               ph_times_in.valve_ms = wr_ms;
               ph_times_in.queue_ms = wr_ms + GAP_MS;
            end
            REG_ORP_OPEN: begin
               orp_seconds_in        = pwdata[SEC_W-1:0];
               orp_times_in.valve_ms = wr_ms;
               orp_times_in.queue_ms = wr_ms + GAP_MS;
            end
            default: begin
               ph_seconds_in = ph_seconds_ff;
            end
         endcase
      end
   end

   // read back
   assign prdata = (sel_reg == REG_ORP_OPEN) ? DATA_W'(orp_seconds_ff)
                                             : DATA_W'(ph_seconds_ff);

   assign ph_times  = ph_times_ff;
   assign orp_times = orp_times_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_seconds_ff         <= OPEN_SECONDS_RST;
         orp_seconds_ff        <= OPEN_SECONDS_RST;
         ph_times_ff.valve_ms  <= CNT_W'(OPEN_SECONDS_RST) * MS_PER_S;
         ph_times_ff.queue_ms  <= CNT_W'(OPEN_SECONDS_RST) * MS_PER_S + GAP_MS;
         orp_times_ff.valve_ms <= CNT_W'(OPEN_SECONDS_RST) * MS_PER_S;
         orp_times_ff.queue_ms <= CNT_W'(OPEN_SECONDS_RST) * MS_PER_S + GAP_MS;
      end else begin
         ph_seconds_ff  <= ph_seconds_in;
         orp_seconds_ff <= orp_seconds_in;
         ph_times_ff    <= ph_times_in;
         orp_times_ff   <= orp_times_in;
      end
   end

endmodule

@@ test/dose_result_checker.sv @@
// result checker of the dosing sequencer: predicts every response and compares it
`timescale 1ns / 1ps

module dose_result_checker
   import dqvds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [ID_W-1:0]       req_valve_id,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_accepted,
   input  logic [NUM_VALVES-1:0] rsp_valve_drive,
   input  logic                  rsp_ph_opened,
   input  logic [ID_W-1:0]       rsp_ph_opened_valve,
   input  logic                  rsp_orp_opened,
   input  logic [ID_W-1:0]       rsp_orp_opened_valve,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending
);

   localparam int PH  = 0;
   localparam int ORP = 1;

   typedef struct packed {
      logic                  accepted;
      logic [NUM_VALVES-1:0] drive;
      logic                  ph_opened;
      logic [ID_W-1:0]       ph_valve;
      logic                  orp_opened;
      logic [ID_W-1:0]       orp_valve;
   } dose_result_type;

   // per-side copy of the sequencer state, index PH or ORP
   logic [ID_W-1:0]  slot [2][QUEUE_DEPTH];
   int unsigned      fill [2];
   logic             valve_open [2];
   logic [ID_W-1:0]  open_id [2];
   logic [CNT_W-1:0] open_ms [2];
   logic [CNT_W-1:0] idle_ms [2];
   logic [SEC_W-1:0] open_secs [2];

   dose_result_type expected_doses [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   // empty a side, close its valve and saturate its dequeue timer
   function automatic void empty_side(input int s);
      fill[s]       = 0;
      valve_open[s] = 1'b0;
      open_id[s]    = '0;
      open_ms[s]    = '0;
      idle_ms[s]    = CNT_MAX;
   endfunction

   // one millisecond on one side: close when due, then dequeue when allowed
   function automatic void tick_side(input int s, output logic opened,
                                     output logic [ID_W-1:0] id);
      logic [CNT_W-1:0] valve_ms;
      logic [CNT_W-1:0] queue_ms;
      valve_ms = CNT_W'(open_secs[s]) * MS_PER_S;
      queue_ms = valve_ms + GAP_MS;
      opened   = 1'b0;
      id       = '0;
      if (open_ms[s] != CNT_MAX) open_ms[s] = open_ms[s] + 1'b1;
      if (idle_ms[s] != CNT_MAX) idle_ms[s] = idle_ms[s] + 1'b1;
      if (valve_open[s] && open_ms[s] >= valve_ms) begin
         valve_open[s] = 1'b0;
         open_id[s]    = '0;
      end
      if (!valve_open[s] && fill[s] > 0 && idle_ms[s] >= queue_ms) begin
         id = slot[s][0];
         for (int i = 0; i + 1 < QUEUE_DEPTH; i++) slot[s][i] = slot[s][i + 1];
         fill[s]       = fill[s] - 1;
         valve_open[s] = 1'b1;
         open_id[s]    = id;
         open_ms[s]    = '0;
         idle_ms[s]    = '0;
         opened        = 1'b1;
      end
   endfunction

   function automatic logic [NUM_VALVES-1:0] side_drive(input int s);
      if (!valve_open[s] || open_id[s] >= NUM_VALVES) return '0;
      return NUM_VALVES'(1) << open_id[s];
   endfunction

   // response that one accepted transaction causes
   function automatic dose_result_type advance_valves(input mode_type m,
                                                      input logic [ID_W-1:0] id);
      dose_result_type r;
      int              s;
      r = '0;
      case (m)
         MODE_TICK: begin
            tick_side(PH, r.ph_opened, r.ph_valve);
            tick_side(ORP, r.orp_opened, r.orp_valve);
         end
         MODE_ENQ: begin
            s = id[0] ? ORP : PH;
            if (id < NUM_VALVES && fill[s] < QUEUE_DEPTH) begin
               slot[s][fill[s]] = id;
               fill[s]          = fill[s] + 1;
               r.accepted       = 1'b1;
            end
         end
         MODE_CLEAR: begin
            empty_side(PH);
            empty_side(ORP);
         end
         default: ;
      endcase
      r.drive = side_drive(PH) | side_drive(ORP);
      return r;
   endfunction

   function automatic int field_err(input string name, input int unsigned want,
                                    input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      dose_result_type want;
      int              errs;
      if (reset) begin
         empty_side(PH);
         empty_side(ORP);
         open_secs[PH]  = OPEN_SECONDS_RST;
         open_secs[ORP] = OPEN_SECONDS_RST;
         expected_doses.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1])
               REG_PH_OPEN:  open_secs[PH]  = csr_pwdata[SEC_W-1:0];
               REG_ORP_OPEN: open_secs[ORP] = csr_pwdata[SEC_W-1:0];
               default: ;
            endcase
         end
         // response transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_doses.size() == 0) begin
               $error("response with no transaction outstanding");
               failures = failures + 1;
            end else begin
               want = expected_doses.pop_front();
               errs = field_err("accepted", want.accepted, rsp_accepted)
                    + field_err("valve_drive", want.drive, rsp_valve_drive)
                    + field_err("ph_opened", want.ph_opened, rsp_ph_opened)
                    + field_err("ph_opened_valve", want.ph_valve, rsp_ph_opened_valve)
                    + field_err("orp_opened", want.orp_opened, rsp_orp_opened)
                    + field_err("orp_opened_valve", want.orp_valve, rsp_orp_opened_valve);
               failures = failures + errs;
            end
         end
         // request transaction
         if (req_valid && !req_stall)
            expected_doses.push_back(advance_valves(mode_type'(req_mode), req_valve_id));
      end
      pending = expected_doses.size();
   end

endmodule

@@ test/tb.sv @@
// stimulus and verdict for the dosing sequencer
`timescale 1ns / 1ps

module tb;
   import dqvds_pkg::*;

   localparam mode_type MODE_SPARE  = 2'd3;
   localparam int       CYCLE_LIMIT = 400000;
   localparam int       SUB_PHASES  = 6;
   localparam int       PHASE_ITEMS = 12;
   localparam int       LONG_TICKS  = 1005;
   localparam int       HOLD_CYCLES = 60;

   // open times per sub-phase, extremes included
   localparam int unsigned PH_SECS  [SUB_PHASES] = '{0, 3600, 1, 2, 0, 750};
   localparam int unsigned ORP_SECS [SUB_PHASES] = '{3600, 0, 2, 3600, 1, 0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   mode_type              req_mode = MODE_TICK;
   logic [ID_W-1:0]       req_valve_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic [NUM_VALVES-1:0] rsp_valve_drive;
   logic                  rsp_ph_opened;
   logic [ID_W-1:0]       rsp_ph_opened_valve;
   logic                  rsp_orp_opened;
   logic [ID_W-1:0]       rsp_orp_opened_valve;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [DATA_W-1:0]     csr_pwdata = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   int                    failures;
   int                    pending;
   int                    sent_count = 0;
   int                    cycle_count = 0;
   int unsigned           send_idle_pct = 32;
   int unsigned           recv_idle_pct = 69;
   bit                    hold_request = 1'b0;

   dual_queue_valve_dosing_sequencer_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_valve_id         (req_valve_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_valve_drive      (rsp_valve_drive),
      .rsp_ph_opened        (rsp_ph_opened),
      .rsp_ph_opened_valve  (rsp_ph_opened_valve),
      .rsp_orp_opened       (rsp_orp_opened),
      .rsp_orp_opened_valve (rsp_orp_opened_valve),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   dose_result_checker dose_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_valve_id         (req_valve_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_valve_drive      (rsp_valve_drive),
      .rsp_ph_opened        (rsp_ph_opened),
      .rsp_ph_opened_valve  (rsp_ph_opened_valve),
      .rsp_orp_opened       (rsp_orp_opened),
      .rsp_orp_opened_valve (rsp_orp_opened_valve),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_pready           (csr_pready),
      .failures             (failures),
      .pending              (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one request transaction, with random idle cycles ahead of it
   task automatic send_item(input mode_type m, input logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_valve_id <= id;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent_count++;
   endtask

   // stop offering and let every outstanding response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input int unsigned secs);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= DATA_W'(secs);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly clear, fill and tick sequences; the rest is single random items or tick runs
   task automatic send_dose_sequence();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if ($urandom_range(2) == 0) send_item(MODE_CLEAR, ID_W'($urandom));
         n = $urandom_range(4, 1);
         repeat (n) begin
            if ($urandom_range(9) == 0)
               send_item(MODE_ENQ, ID_W'($urandom_range(7, 6)));
            else
               send_item(MODE_ENQ, ID_W'($urandom_range(5)));
         end
         n = $urandom_range(12, 1);
         repeat (n) send_item(MODE_TICK, ID_W'($urandom));
      end else if (pick < 80) begin
         send_item(mode_type'($urandom_range(3)), ID_W'($urandom_range(7)));
      end else begin
         n = $urandom_range(30, 1);
         repeat (n) send_item(MODE_TICK, ID_W'($urandom));
      end
   endtask

   initial begin
      int phase_end;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset open times
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_SPARE, 3'd7);
      send_item(MODE_ENQ, 3'd7);
      send_item(MODE_ENQ, 3'd6);
      send_item(MODE_ENQ, 3'd0);
      send_item(MODE_ENQ, 3'd2);
      send_item(MODE_ENQ, 3'd4);
      send_item(MODE_ENQ, 3'd0);   // ph queue full
      send_item(MODE_ENQ, 3'd1);
      send_item(MODE_ENQ, 3'd3);
      send_item(MODE_ENQ, 3'd5);
      send_item(MODE_ENQ, 3'd5);   // orp queue full
      send_item(MODE_TICK, 3'd7);  // first dequeue on both sides
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_ENQ, 3'd2);
      send_item(MODE_SPARE, 3'd0);
      send_item(MODE_CLEAR, 3'd3);
      send_item(MODE_TICK, 3'd5);
      send_item(MODE_ENQ, 3'd4);
      send_item(MODE_ENQ, 3'd3);
      send_item(MODE_TICK, 3'd2);  // immediate again after clear
      send_item(MODE_TICK, 3'd1);
      send_item(MODE_CLEAR, 3'd4);

      // random part over several open times and idling patterns
      for (int sub = 0; sub < SUB_PHASES; sub++) begin
         wait_idle();
         csr_write(REG_PH_OPEN, PH_SECS[sub]);
         csr_write(REG_ORP_OPEN, ORP_SECS[sub]);
         case (sub / 2)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (sub % 2 == 0) hold_request = 1'b1;
         // long tick run so that a one-second open time runs out
         if (sub == 4) begin
            send_item(MODE_CLEAR, 3'd0);
            send_item(MODE_ENQ, 3'd0);
            send_item(MODE_ENQ, 3'd1);
            send_item(MODE_ENQ, 3'd2);
            send_item(MODE_ENQ, 3'd3);
            repeat (LONG_TICKS) send_item(MODE_TICK, ID_W'($urandom));
         end
         phase_end = sent_count + PHASE_ITEMS;
         while (sent_count < phase_end) send_dose_sequence();
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
